FILE: rtl/mtl_pkg.sv
package mtl_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 99;
    localparam int LEN_W             = 8;
    localparam int BUNDLE_MAX        = 3;
    localparam int CNT_W             = 2;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_BAR   = 8'h7c;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [2:0] KIND_STRING  = 3'd0;
    localparam logic [2:0] KIND_TAG     = 3'd1;
    localparam logic [2:0] KIND_NUMBER  = 3'd2;
    localparam logic [2:0] KIND_IDENT   = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN = 3'd4;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_TAG    = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_IDENT  = 3'd3,
        MODE_SKIP   = 3'd4,
        MODE_STRING = 3'd5,
        MODE_BAR    = 3'd6
    } t_mode;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] token_char;
        logic       has_char;
        logic       token_end;
        logic       truncated;
        logic       last_result;
    } t_result;

    typedef struct packed {
        t_result [BUNDLE_MAX-1:0] items;
        logic [CNT_W-1:0]         cnt;
    } t_bundle;

    typedef struct packed {
        logic push;
        logic idle;
    } t_front_status;

    function automatic logic f_is_num(input logic [7:0] c);
        return (c inside {["0":"9"]}) || c == CH_DOT || c == CH_MINUS;
    endfunction

    function automatic logic f_is_letter(input logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"]});
    endfunction

    function automatic logic [2:0] f_mode_kind(input t_mode m);
        logic [2:0] k;
        case (m)
            MODE_TAG:    k = KIND_TAG;
            MODE_NUMBER: k = KIND_NUMBER;
            MODE_IDENT:  k = KIND_IDENT;
            default:     k = KIND_STRING;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/mtl_front.sv
module mtl_front
    import mtl_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_char,
    input  logic          i_eot,
    output t_bundle       o_bundle,
    output t_front_status o_status
);

    typedef struct packed {
        t_mode            mode;
        logic [LEN_W-1:0] len;
        logic             ovf;
        t_bundle          b;
    } t_lex;

    t_mode            r_mode, n_mode;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_ovf, n_ovf;
    t_bundle          v_bundle;

    function automatic t_lex f_emit(input t_lex st, input logic [2:0] kind,
                                    input logic [7:0] ch, input logic has,
                                    input logic tend, input logic trunc);
        t_lex s;
        s = st;
        s.b.items[s.b.cnt] = '{kind: kind, token_char: ch, has_char: has,
                               token_end: tend, truncated: trunc, last_result: 1'b0};
        s.b.cnt = s.b.cnt + CNT_W'(1);
        return s;
    endfunction

    function automatic t_lex f_add(input t_lex st, input logic [7:0] c);
        t_lex s;
        s = st;
        if (s.len < LEN_W'(MAX_TOKEN_LEN)) begin
            s = f_emit(s, f_mode_kind(s.mode), c, 1'b1, 1'b0, 1'b0);
            s.len = s.len + LEN_W'(1);
        end else begin
            s.ovf = 1'b1;
        end
        return s;
    endfunction

    function automatic t_lex f_close(input t_lex st);
        t_lex s;
        s = f_emit(st, f_mode_kind(st.mode), 8'h00, 1'b0, 1'b1, st.ovf);
        s.mode = MODE_IDLE;
        s.len  = '0;
        s.ovf  = 1'b0;
        return s;
    endfunction

    function automatic t_lex f_start(input t_lex st, input logic [7:0] c);
        t_lex s;
        s = st;
        s.len = '0;
        s.ovf = 1'b0;
        if (c == CH_SPACE || c == CH_LF || c == CH_TAB) begin
            s.mode = MODE_IDLE;
        end else if (c == CH_LT) begin
            s.mode = MODE_TAG;
        end else if (f_is_num(c)) begin
            s.mode = MODE_NUMBER;
            s = f_add(s, c);
        end else if (f_is_letter(c)) begin
            s.mode = MODE_IDENT;
            s = f_add(s, c);
        end else if (c == CH_BAR) begin
            s.mode = MODE_SKIP;
        end else begin
            s.mode = MODE_IDLE;
            s = f_emit(s, KIND_UNKNOWN, c, 1'b1, 1'b0, 1'b0);
        end
        return s;
    endfunction

    always_comb begin
        t_lex s;
        s.mode = r_mode;
        s.len  = r_len;
        s.ovf  = r_ovf;
        s.b    = '0;
        case (r_mode)
            MODE_TAG: begin
                if (i_char == CH_GT) s = f_close(s);
                else                 s = f_add(s, i_char);
            end
            MODE_NUMBER: begin
                if (f_is_num(i_char)) begin
                    s = f_add(s, i_char);
                end else begin
                    s = f_close(s);
                    s = f_start(s, i_char);
                end
            end
            MODE_IDENT: begin
                if (f_is_letter(i_char)) begin
                    s = f_add(s, i_char);
                end else begin
                    s = f_close(s);
                    s = f_start(s, i_char);
                end
            end
            MODE_SKIP: begin
                s.mode = MODE_STRING;
            end
            MODE_STRING: begin
                if (i_char == CH_BAR) s.mode = MODE_BAR;
                else                  s = f_add(s, i_char);
            end
            MODE_BAR: begin
                if (i_char == CH_BAR) begin
                    s = f_close(s);
                end else begin
                    s.mode = MODE_STRING;
                    s = f_add(s, CH_BAR);
                    s = f_add(s, i_char);
                end
            end
            default: begin
                s = f_start(s, i_char);
            end
        endcase
        if (i_eot && s.mode != MODE_IDLE) begin
            if (s.mode == MODE_BAR) s = f_add(s, CH_BAR);
            s = f_close(s);
        end
        if (i_eot) begin
            s.mode = MODE_IDLE;
            s.len  = '0;
            s.ovf  = 1'b0;
        end
        // flag the final result of this byte
        if (s.b.cnt != '0) s.b.items[s.b.cnt - CNT_W'(1)].last_result = 1'b1;
        n_mode   = s.mode;
        n_len    = s.len;
        n_ovf    = s.ovf;
        v_bundle = s.b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_len  <= '0;
            r_ovf  <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_ovf  <= n_ovf;
        end
    end

    assign o_bundle      = v_bundle;
    assign o_status.push = i_accept && (v_bundle.cnt != '0);
    assign o_status.idle = (r_mode == MODE_IDLE);

endmodule

FILE: rtl/mtl_queue.sv
module mtl_queue
    import mtl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_bundle o_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_bundle           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              v_push, v_pop;

    assign o_full  = (r_count == CNT_QW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign v_push  = i_push && !o_full;
    assign v_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (v_push) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (v_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (v_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (v_push && !v_pop)      r_count <= r_count + CNT_QW'(1);
            else if (v_pop && !v_push) r_count <= r_count - CNT_QW'(1);
        end
    end

endmodule

FILE: rtl/mtl_back.sv
module mtl_back
    import mtl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_bundle i_q_data,
    output logic    o_q_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic             r_valid;
    t_bundle          r_bundle;
    logic [CNT_W-1:0] r_idx;
    logic             v_fire, v_done, v_load;

    assign v_fire  = r_valid && i_ready;
    assign v_done  = v_fire && (r_idx == r_bundle.cnt - CNT_W'(1));
    assign v_load  = !r_valid || v_done;
    assign o_q_pop = v_load && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (v_load) begin
            r_valid <= i_q_valid;
            r_idx   <= '0;
        end else if (v_fire) begin
            r_idx   <= r_idx + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_load) r_bundle <= i_q_data;
    end

    assign o_valid  = r_valid;
    assign o_result = r_bundle.items[r_idx];

endmodule

FILE: rtl/markup_token_lexer.sv
// Markup token lexer: takes one text byte per transaction and emits each token
// character, up to MAX_TOKEN_LEN per token, as its own result tagged with the
// token kind (string, tag, number, identifier), closing each token with an end
// marker; unrecognized bytes give a single result. A byte is accepted every cycle
// while the four-entry bundle queue between the lexer front and the output stage
// has room; the output port delivers one result per cycle while the receiver is
// ready, so a byte that causes n results (0 to 3) holds the output until all n
// are taken; sustained throughput is one byte per cycle while the average stays
// at one result per byte. Results pass through the queue and the output register.
module markup_token_lexer
    import mtl_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // char_byte[7:0]
    input  logic        i_s_tlast,  // end_of_text
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // token_char[7:0], truncated[8], last_result[9], zero
    output logic [3:0]  o_m_tuser,  // kind[2:0], has_char[3]
    output logic        o_m_tlast   // token_end
);

    logic          v_accept;
    logic          v_full;
    logic          v_q_valid;
    logic          v_q_pop;
    t_bundle       v_push_data;
    t_bundle       v_q_data;
    t_front_status v_front;
    t_result       v_res;

    assign o_s_tready = !v_full;
    assign v_accept   = i_s_tvalid && o_s_tready;

    mtl_front #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (v_accept),
        .i_char   (i_s_tdata),
        .i_eot    (i_s_tlast),
        .o_bundle (v_push_data),
        .o_status (v_front)
    );

    mtl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (v_front.push),
        .i_data  (v_push_data),
        .o_full  (v_full),
        .i_pop   (v_q_pop),
        .o_valid (v_q_valid),
        .o_data  (v_q_data)
    );

    mtl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (v_q_valid),
        .i_q_data  (v_q_data),
        .o_q_pop   (v_q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_result  (v_res)
    );

    assign o_m_tdata = {6'b0, v_res.last_result, v_res.truncated, v_res.token_char};
    assign o_m_tuser = {v_res.has_char, v_res.kind};
    assign o_m_tlast = v_res.token_end;

    a_eot_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v_accept && i_s_tlast) |=> v_front.idle)
        else $error("lexer not idle after end of text");

    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v_front.push |-> (v_push_data.cnt != '0) && v_push_data.items[0].kind <= KIND_UNKNOWN)
        else $error("empty bundle pushed");

    a_trunc_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[8]) |-> (o_m_tlast && !o_m_tuser[3]))
        else $error("truncated flag outside end marker");

endmodule
